FILE: rtl/core/indexed_list_store_macros.svh
// Assertion macros used by the list store top level
`ifndef INDEXED_LIST_STORE_MACROS_SVH
`define INDEXED_LIST_STORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ILS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list store check failed");

`define ILS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list store check failed");

`else

`define ILS_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define ILS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/ils_pkg.sv
// Types and constants for the indexed list store
package ils_pkg;

    localparam int CAPACITY = 64;
    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int ST_W     = 2;
    localparam int OCNT_W   = 7;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int S_DATA_W = ((OP_W + POS_W + VAL_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((VAL_W + ST_W + OCNT_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_READ      = 3'd0,
        OP_INS_FRONT = 3'd1,
        OP_INS_BACK  = 3'd2,
        OP_INS_AT    = 3'd3,
        OP_DELETE    = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic             ins;
        logic             del;
        logic [CMP_W-1:0] pos;
        logic [VAL_W-1:0] value;
    } cmd_t;

endpackage

FILE: rtl/core/ils_cell.sv
// One slot of the list store: holds, loads, or shifts from a neighbour
module ils_cell (
    input  logic                      aclk,
    input  ils_pkg::cmd_t             cmd,
    input  logic [ils_pkg::CMP_W-1:0] idx,
    input  logic [ils_pkg::VAL_W-1:0] left_value,
    input  logic [ils_pkg::VAL_W-1:0] right_value,
    output logic [ils_pkg::VAL_W-1:0] slot_value,
    output logic [ils_pkg::VAL_W-1:0] hit_value
);

    logic [ils_pkg::VAL_W-1:0] slot_reg;
    logic [ils_pkg::VAL_W-1:0] slot_next;

    always_comb begin
        slot_next = slot_reg;
        priority if (cmd.ins && (idx == cmd.pos)) begin
            slot_next = cmd.value;
        end else if (cmd.ins && (idx > cmd.pos)) begin
            slot_next = left_value;
        end else if (cmd.del && (idx >= cmd.pos)) begin
            slot_next = right_value;
        end else begin
            slot_next = slot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    assign slot_value = slot_reg;
    assign hit_value  = (idx == cmd.pos) ? slot_reg : '0;

endmodule

FILE: rtl/core/indexed_list_store.sv
// Indexed list store: top level with request decode, cell chain and result register
// A request's result word is registered and appears in the cycle after the request is taken.
// Throughput: one request per cycle while s_tready is high; every cell loads, shifts or holds in the same cycle.
// s_tready drops only while a result word waits and m_tready is low.
// Reset (aresetn low, synchronous) empties the list and drops m_tvalid;
// slot contents are not cleared and are read only below the entry count.
`include "indexed_list_store_macros.svh"

module indexed_list_store (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // op [2:0], position [9:3], item_value [41:10], zero [47:42]
    input  logic [ils_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // read_value [31:0], status [33:32], entry_count [40:34], zero [47:41]
    output logic [ils_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int POS_LO = ils_pkg::OP_W;
    localparam int VAL_LO = ils_pkg::OP_W + ils_pkg::POS_W;
    localparam int ST_LO  = ils_pkg::VAL_W;
    localparam int CNT_LO = ils_pkg::VAL_W + ils_pkg::ST_W;
    localparam int M_USED = ils_pkg::VAL_W + ils_pkg::ST_W + ils_pkg::OCNT_W;

    logic [ils_pkg::OP_W-1:0]  op_raw;
    logic [ils_pkg::POS_W-1:0] position;
    logic [ils_pkg::VAL_W-1:0] item_value;
    logic                      s_acc;

    logic [ils_pkg::CNT_W-1:0] count_reg;
    logic [ils_pkg::CNT_W-1:0] count_next;
    logic                      m_tvalid_reg;
    logic                      m_tvalid_next;
    logic [ils_pkg::VAL_W-1:0] rv_reg;
    logic [ils_pkg::VAL_W-1:0] rv_next;
    ils_pkg::status_t          st_reg;
    ils_pkg::status_t          st_next;

    logic [ils_pkg::CMP_W-1:0] pos_ext;
    logic [ils_pkg::CMP_W-1:0] cnt_ext;
    logic                      full;
    ils_pkg::cmd_t             cmd;
    logic [ils_pkg::VAL_W-1:0] rd_value;

    logic [ils_pkg::VAL_W-1:0] slot_value [ils_pkg::CAPACITY];
    logic [ils_pkg::VAL_W-1:0] hit_value  [ils_pkg::CAPACITY];

    assign op_raw     = s_tdata[POS_LO-1:0];
    assign position   = s_tdata[VAL_LO-1:POS_LO];
    assign item_value = s_tdata[VAL_LO+ils_pkg::VAL_W-1:VAL_LO];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;

    assign pos_ext = ils_pkg::CMP_W'(position);
    assign cnt_ext = ils_pkg::CMP_W'(count_reg);
    assign full    = (count_reg == ils_pkg::CNT_W'(ils_pkg::CAPACITY));

    always_comb begin
        cmd.ins    = 1'b0;
        cmd.del    = 1'b0;
        cmd.pos    = pos_ext;
        cmd.value  = item_value;
        rv_next    = '0;
        st_next    = ils_pkg::ST_DONE;
        count_next = count_reg;
        unique case (ils_pkg::op_t'(op_raw))
            ils_pkg::OP_READ: begin
                if (pos_ext < cnt_ext) begin
                    rv_next = rd_value;
                end else begin
                    rv_next = '1;
                    st_next = ils_pkg::ST_RANGE;
                end
            end
            ils_pkg::OP_INS_FRONT: begin
                cmd.pos = '0;
                if (full) begin
                    st_next = ils_pkg::ST_FULL;
                end else begin
                    cmd.ins = s_acc;
                end
            end
            ils_pkg::OP_INS_BACK: begin
                cmd.pos = cnt_ext;
                if (full) begin
                    st_next = ils_pkg::ST_FULL;
                end else begin
                    cmd.ins = s_acc;
                end
            end
            ils_pkg::OP_INS_AT: begin
                if (pos_ext > cnt_ext) begin
                    st_next = ils_pkg::ST_RANGE;
                end else if (full) begin
                    st_next = ils_pkg::ST_FULL;
                end else begin
                    cmd.ins = s_acc;
                end
            end
            ils_pkg::OP_DELETE: begin
                if (pos_ext >= cnt_ext) begin
                    st_next = ils_pkg::ST_RANGE;
                end else begin
                    cmd.del = s_acc;
                end
            end
            default: begin
            end
        endcase
        if (cmd.ins) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.del) begin
            count_next = count_reg - 1'b1;
        end
    end

    for (genvar k = 0; k < ils_pkg::CAPACITY; k++) begin : g_cell
        logic [ils_pkg::VAL_W-1:0] left_value;
        logic [ils_pkg::VAL_W-1:0] right_value;

        if (k == 0) begin : g_first
            assign left_value = item_value;
        end else begin : g_mid_l
            assign left_value = slot_value[k-1];
        end

        if (k == ils_pkg::CAPACITY - 1) begin : g_last
            assign right_value = slot_value[k];
        end else begin : g_mid_r
            assign right_value = slot_value[k+1];
        end

        ils_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .idx         (ils_pkg::CMP_W'(k)),
            .left_value  (left_value),
            .right_value (right_value),
            .slot_value  (slot_value[k]),
            .hit_value   (hit_value[k])
        );
    end

    always_comb begin
        rd_value = '0;
        for (int k = 0; k < ils_pkg::CAPACITY; k++) begin
            rd_value = rd_value | hit_value[k];
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (s_acc) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            rv_reg <= rv_next;
            st_reg <= st_next;
        end
    end

    assign m_tvalid                        = m_tvalid_reg;
    assign m_tdata[ST_LO-1:0]              = rv_reg;
    assign m_tdata[CNT_LO-1:ST_LO]         = st_reg;
    assign m_tdata[M_USED-1:CNT_LO]        = ils_pkg::OCNT_W'(count_reg);
    assign m_tdata[ils_pkg::M_DATA_W-1:M_USED] = '0;

    `ILS_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= ils_pkg::CNT_W'(ils_pkg::CAPACITY))
    `ILS_ASSERT_NEXT(a_result_follows, aclk, aresetn, s_acc, m_tvalid)
    `ILS_ASSERT_NEXT(a_count_idle, aclk, aresetn, !s_acc, $stable(count_reg))
    `ILS_ASSERT_SAME(a_full_status, aclk, aresetn, m_tvalid && (st_reg == ils_pkg::ST_FULL), full)

endmodule
